// File: hdl/sts_pkg.sv
// sts_pkg: shared constants, tables and types for the sine taylor series block
// used by sine_taylor_series; no dependencies

package sts_pkg;

   localparam int MAX_TERMS_DEFAULT = 16;

   // field widths
   localparam int ANGLE_W = 32;
   localparam int SINE_W  = 32;
   localparam int TERMS_W = 5;
   localparam int TOL_W   = 31;

   localparam logic [TOL_W-1:0] TOL_RESET = 31'd10737;

   // datapath widths
   localparam int REM_W     = 40;   // |angle| in Q.32 during reduction
   localparam int MAG_W     = 32;   // |c| in Q.30
   localparam int TERM_W    = 34;   // term magnitude and c^2 in Q.30
   localparam int PROD_W    = 37;   // floor(t * c^2 / 2^30)
   localparam int SUM_W     = 37;   // signed running sum
   localparam int CHUNK_W   = 18;
   localparam int MUL_A_W   = 3 * CHUNK_W;
   localparam int MUL_B_W   = 36;
   localparam int ACC_W     = MUL_A_W + MUL_B_W;
   localparam int DIV_W     = 12;
   localparam int RECIP_W   = 36;
   localparam int IDX_W     = 5;
   localparam int STEP_W    = 3;
   localparam int FRAC_SHIFT  = 30;
   localparam int RECIP_SHIFT = 38;

   localparam logic [REM_W-1:0] TWO_PI_Q32 = 40'h6_487E_D511;
   localparam logic [REM_W-1:0] PI_Q32     = 40'h3_243F_6A88;
   localparam logic [STEP_W-1:0] RED_STEPS_LAST = 3'd4;

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2147483647);
   localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

   // divisors l(l+1) for l = 2, 4, ..., 62 and their Q.38 reciprocals
   localparam int TABLE_DEPTH = 31;
   localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;

   localparam logic [DIV_W-1:0] DIVISOR_TABLE [TABLE_DEPTH] = '{
      12'd6,    12'd20,   12'd42,   12'd72,   12'd110,  12'd156,  12'd210,  12'd272,
      12'd342,  12'd420,  12'd506,  12'd600,  12'd702,  12'd812,  12'd930,  12'd1056,
      12'd1190, 12'd1332, 12'd1482, 12'd1640, 12'd1806, 12'd1980, 12'd2162, 12'd2352,
      12'd2550, 12'd2756, 12'd2970, 12'd3192, 12'd3422, 12'd3660, 12'd3906
   };

   localparam logic [RECIP_W-1:0] RECIP_TABLE [TABLE_DEPTH] = '{
      RECIP_W'(RECIP_ONE / 64'd6),    RECIP_W'(RECIP_ONE / 64'd20),
      RECIP_W'(RECIP_ONE / 64'd42),   RECIP_W'(RECIP_ONE / 64'd72),
      RECIP_W'(RECIP_ONE / 64'd110),  RECIP_W'(RECIP_ONE / 64'd156),
      RECIP_W'(RECIP_ONE / 64'd210),  RECIP_W'(RECIP_ONE / 64'd272),
      RECIP_W'(RECIP_ONE / 64'd342),  RECIP_W'(RECIP_ONE / 64'd420),
      RECIP_W'(RECIP_ONE / 64'd506),  RECIP_W'(RECIP_ONE / 64'd600),
      RECIP_W'(RECIP_ONE / 64'd702),  RECIP_W'(RECIP_ONE / 64'd812),
      RECIP_W'(RECIP_ONE / 64'd930),  RECIP_W'(RECIP_ONE / 64'd1056),
      RECIP_W'(RECIP_ONE / 64'd1190), RECIP_W'(RECIP_ONE / 64'd1332),
      RECIP_W'(RECIP_ONE / 64'd1482), RECIP_W'(RECIP_ONE / 64'd1640),
      RECIP_W'(RECIP_ONE / 64'd1806), RECIP_W'(RECIP_ONE / 64'd1980),
      RECIP_W'(RECIP_ONE / 64'd2162), RECIP_W'(RECIP_ONE / 64'd2352),
      RECIP_W'(RECIP_ONE / 64'd2550), RECIP_W'(RECIP_ONE / 64'd2756),
      RECIP_W'(RECIP_ONE / 64'd2970), RECIP_W'(RECIP_ONE / 64'd3192),
      RECIP_W'(RECIP_ONE / 64'd3422), RECIP_W'(RECIP_ONE / 64'd3660),
      RECIP_W'(RECIP_ONE / 64'd3906)
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED,
      ST_WRAP,
      ST_SQ,
      ST_C2,
      ST_TM,
      ST_P,
      ST_RC,
      ST_Q,
      ST_QD,
      ST_UPD,
      ST_OUT
   } state_type;

endpackage

// File: hdl/sine_taylor_series.sv
// sine_taylor_series: sine of a Q8.24 angle by range reduction and a Taylor series
// one shared 18x36 multiply-accumulate unit under a state machine; uses sts_pkg
//
//   channel  dir   handshake              payload
//   req      in    req_tvalid/req_tready  tdata: angle
//   rsp      out   rsp_tvalid/rsp_tready  tdata: sine_value, terms_used; tuser: limit_hit
//   csr      in    csr_valid/csr_ready    csr_data: tolerance
//
// an angle goes from request to result register through:
// 5 restoring reduction steps, a wrap, the squaring, then per term 2 + 3 + 1 passes
// of the shared multiplier (t * c^2, reciprocal of l(l+1), remainder check) plus moves.
// req_tready is high only in idle; one request is in flight at a time.
// the result register lets a new request in while the last result waits on rsp_tready.
// reset is synchronous; tolerance returns to 10737.

module sine_taylor_series #(
   parameter int MAX_TERMS = sts_pkg::MAX_TERMS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [31:0]                 req_tdata,   // angle[31:0]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [39:0]                 rsp_tdata,   // sine_value[31:0], terms_used[36:32], zero
   output logic [0:0]                  rsp_tuser,   // limit_hit
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [sts_pkg::TOL_W-1:0]   csr_data
);

   localparam int CNT_W = $clog2(MAX_TERMS + 1);

   sts_pkg::state_type state_ff, state_in, ret_ff, ret_in;

   logic [sts_pkg::TOL_W-1:0]    tol_ff, tol_in;
   logic [sts_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic                         sign_ff, sign_in;
   logic [sts_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                         neg_ff, neg_in;
   logic [sts_pkg::TERM_W-1:0]   c2_ff, c2_in;
   logic [sts_pkg::TERM_W-1:0]   t_ff, t_in;
   logic [sts_pkg::PROD_W-1:0]   p_ff, p_in;
   logic [sts_pkg::TERM_W-1:0]   q_ff, q_in;
   logic signed [sts_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         limit_ff, limit_in;
   logic [sts_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [sts_pkg::MUL_A_W-1:0]  mul_a_ff, mul_a_in;
   logic [sts_pkg::MUL_B_W-1:0]  mul_b_ff, mul_b_in;
   logic [1:0]                   chunk_ff, chunk_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sts_pkg::SINE_W-1:0]   rsp_sine_ff, rsp_sine_in;
   logic [sts_pkg::TERMS_W-1:0]  rsp_terms_ff, rsp_terms_in;
   logic                         rsp_limit_ff, rsp_limit_in;
   logic                         rsp_load;

   logic [sts_pkg::ANGLE_W-1:0]  angle_abs;
   logic [sts_pkg::REM_W-1:0]    red_div;
   logic                         red_ge;
   logic                         fold;
   logic [sts_pkg::REM_W-1:0]    wrap_full;
   logic [sts_pkg::MAG_W-1:0]    wrap_mag;
   logic                         wrap_neg;
   logic [sts_pkg::MUL_A_W-1:0]  partial;
   logic [sts_pkg::ACC_W-1:0]    acc_step;
   logic [sts_pkg::IDX_W-1:0]    tbl_idx;
   logic [sts_pkg::DIV_W-1:0]    div_sel;
   logic [sts_pkg::RECIP_W-1:0]  recip_sel;
   logic [sts_pkg::PROD_W-1:0]   qd_rem;
   logic [sts_pkg::TERM_W-1:0]   q_fix;
   logic signed [sts_pkg::SUM_W-1:0] sum_next;
   logic [CNT_W-1:0]             count_inc;
   logic [sts_pkg::SINE_W-1:0]   sum_sat;

   // datapath helpers
   assign angle_abs = req_tdata[31] ? 32'(-req_tdata) : req_tdata;
   assign red_div   = sts_pkg::TWO_PI_Q32 << step_ff;
   assign red_ge    = rem_ff >= red_div;
   assign fold      = rem_ff > sts_pkg::PI_Q32;
   assign wrap_full = fold ? sts_pkg::TWO_PI_Q32 - rem_ff : rem_ff;
   assign wrap_mag  = sts_pkg::MAG_W'(wrap_full >> 2);
   assign wrap_neg  = (sign_ff ^ fold) && (wrap_full != '0);

   // shared multiplier, top chunk first
   assign partial  = mul_a_ff[sts_pkg::MUL_A_W-1 -: sts_pkg::CHUNK_W] * mul_b_ff;
   assign acc_step = {acc_ff[sts_pkg::ACC_W-sts_pkg::CHUNK_W-1:0], sts_pkg::CHUNK_W'(0)}
                     + sts_pkg::ACC_W'(partial);

   assign tbl_idx   = sts_pkg::IDX_W'(count_ff - CNT_W'(1));
   assign div_sel   = sts_pkg::DIVISOR_TABLE[tbl_idx];
   assign recip_sel = sts_pkg::RECIP_TABLE[tbl_idx];

   assign qd_rem    = p_ff - acc_ff[sts_pkg::PROD_W-1:0];
   assign q_fix     = q_ff + sts_pkg::TERM_W'(qd_rem >= sts_pkg::PROD_W'(div_sel));
   assign sum_next  = neg_ff ? sum_ff + $signed(sts_pkg::SUM_W'(q_fix))
                             : sum_ff - $signed(sts_pkg::SUM_W'(q_fix));
   assign count_inc = count_ff + CNT_W'(1);

   always_comb begin
      priority if (sum_ff > sts_pkg::SAT_HI) begin
         sum_sat = sts_pkg::SINE_W'(sts_pkg::SAT_HI);
      end else if (sum_ff < sts_pkg::SAT_LO) begin
         sum_sat = sts_pkg::SINE_W'(sts_pkg::SAT_LO);
      end else begin
         sum_sat = sum_ff[sts_pkg::SINE_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      rem_in     = rem_ff;
      sign_in    = sign_ff;
      step_in    = step_ff;
      neg_in     = neg_ff;
      c2_in      = c2_ff;
      t_in       = t_ff;
      p_in       = p_ff;
      q_in       = q_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      limit_in   = limit_ff;
      acc_in     = acc_ff;
      mul_a_in   = mul_a_ff;
      mul_b_in   = mul_b_ff;
      chunk_in   = chunk_ff;
      req_tready = 1'b0;
      rsp_load   = 1'b0;

      unique case (state_ff)
         sts_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               rem_in   = {angle_abs, 8'b0};
               sign_in  = req_tdata[31];
               step_in  = sts_pkg::RED_STEPS_LAST;
               state_in = sts_pkg::ST_RED;
            end
         end
         sts_pkg::ST_RED: begin
            if (red_ge) begin
               rem_in = rem_ff - red_div;
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = sts_pkg::ST_WRAP;
            end
         end
         sts_pkg::ST_WRAP: begin
            neg_in   = wrap_neg;
            t_in     = sts_pkg::TERM_W'(wrap_mag);
            sum_in   = wrap_neg ? -$signed(sts_pkg::SUM_W'(wrap_mag))
                                :  $signed(sts_pkg::SUM_W'(wrap_mag));
            count_in = CNT_W'(1);
            mul_a_in = sts_pkg::MUL_A_W'(wrap_mag) << sts_pkg::CHUNK_W;
            mul_b_in = sts_pkg::MUL_B_W'(wrap_mag);
            chunk_in = 2'd1;
            acc_in   = '0;
            ret_in   = sts_pkg::ST_C2;
            state_in = sts_pkg::ST_SQ;
         end
         sts_pkg::ST_SQ, sts_pkg::ST_TM, sts_pkg::ST_RC, sts_pkg::ST_QD: begin
            acc_in   = acc_step;
            mul_a_in = mul_a_ff << sts_pkg::CHUNK_W;
            chunk_in = chunk_ff - 1'b1;
            if (chunk_ff == '0) begin
               state_in = ret_ff;
            end
         end
         sts_pkg::ST_C2: begin
            c2_in    = acc_ff[sts_pkg::FRAC_SHIFT +: sts_pkg::TERM_W];
            mul_a_in = sts_pkg::MUL_A_W'(t_ff) << sts_pkg::CHUNK_W;
            mul_b_in = sts_pkg::MUL_B_W'(acc_ff[sts_pkg::FRAC_SHIFT +: sts_pkg::TERM_W]);
            chunk_in = 2'd1;
            acc_in   = '0;
            ret_in   = sts_pkg::ST_P;
            state_in = sts_pkg::ST_TM;
         end
         sts_pkg::ST_P: begin
            p_in     = acc_ff[sts_pkg::FRAC_SHIFT +: sts_pkg::PROD_W];
            mul_a_in = sts_pkg::MUL_A_W'(acc_ff[sts_pkg::FRAC_SHIFT +: sts_pkg::PROD_W]);
            mul_b_in = recip_sel;
            chunk_in = 2'd2;
            acc_in   = '0;
            ret_in   = sts_pkg::ST_Q;
            state_in = sts_pkg::ST_RC;
         end
         sts_pkg::ST_Q: begin
            q_in     = acc_ff[sts_pkg::RECIP_SHIFT +: sts_pkg::TERM_W];
            mul_a_in = sts_pkg::MUL_A_W'(div_sel) << (2 * sts_pkg::CHUNK_W);
            mul_b_in = sts_pkg::MUL_B_W'(acc_ff[sts_pkg::RECIP_SHIFT +: sts_pkg::TERM_W]);
            chunk_in = 2'd0;
            acc_in   = '0;
            ret_in   = sts_pkg::ST_UPD;
            state_in = sts_pkg::ST_QD;
         end
         sts_pkg::ST_UPD: begin
            t_in     = q_fix;
            sum_in   = sum_next;
            neg_in   = !neg_ff;
            count_in = count_inc;
            priority if (q_fix < sts_pkg::TERM_W'(tol_ff)) begin
               limit_in = 1'b0;
               state_in = sts_pkg::ST_OUT;
            end else if (count_inc == CNT_W'(MAX_TERMS)) begin
               limit_in = 1'b1;
               state_in = sts_pkg::ST_OUT;
            end else begin
               mul_a_in = sts_pkg::MUL_A_W'(q_fix) << sts_pkg::CHUNK_W;
               mul_b_in = sts_pkg::MUL_B_W'(c2_ff);
               chunk_in = 2'd1;
               acc_in   = '0;
               ret_in   = sts_pkg::ST_P;
               state_in = sts_pkg::ST_TM;
            end
         end
         sts_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = sts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sts_pkg::ST_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sine_in  = rsp_sine_ff;
      rsp_terms_in = rsp_terms_ff;
      rsp_limit_in = rsp_limit_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_sine_in  = sum_sat;
         rsp_terms_in = sts_pkg::TERMS_W'(count_ff);
         rsp_limit_in = limit_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign tol_in = csr_valid ? csr_data : tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sts_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tol_ff       <= sts_pkg::TOL_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tol_ff       <= tol_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff       <= ret_in;
      rem_ff       <= rem_in;
      sign_ff      <= sign_in;
      step_ff      <= step_in;
      neg_ff       <= neg_in;
      c2_ff        <= c2_in;
      t_ff         <= t_in;
      p_ff         <= p_in;
      q_ff         <= q_in;
      sum_ff       <= sum_in;
      count_ff     <= count_in;
      limit_ff     <= limit_in;
      acc_ff       <= acc_in;
      mul_a_ff     <= mul_a_in;
      mul_b_ff     <= mul_b_in;
      chunk_ff     <= chunk_in;
      rsp_sine_ff  <= rsp_sine_in;
      rsp_terms_ff <= rsp_terms_in;
      rsp_limit_ff <= rsp_limit_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b0, rsp_terms_ff, rsp_sine_ff};
   assign rsp_tuser  = rsp_limit_ff;

   // checks
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   a_reduced_below_two_pi: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sts_pkg::ST_WRAP) |-> (rem_ff < sts_pkg::TWO_PI_Q32))
      else $error("reduction left remainder at or above two pi");

   a_wrapped_within_pi: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sts_pkg::ST_C2) |->
         (t_ff <= sts_pkg::TERM_W'(sts_pkg::PI_Q32 >> 2)))
      else $error("wrapped magnitude above pi");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sts_pkg::ST_UPD) |-> (count_ff < CNT_W'(MAX_TERMS)))
      else $error("term count past limit");

   a_limit_means_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         (rsp_tdata[36:32] == sts_pkg::TERMS_W'(MAX_TERMS)))
      else $error("limit flag without full term count");

endmodule

// File: tb/sine_taylor_series_tb.sv
// sine_taylor_series_tb: self-checking bench for the sine taylor series block
// drives random and corner angles over several tolerance settings with random idling,
// predicts sine, term count and limit flag in a scoreboard class; uses sts_pkg

module sine_taylor_series_tb;

   localparam int     SERIES_TERMS = sts_pkg::MAX_TERMS_DEFAULT;
   localparam int     PHASES       = 8;
   localparam int     PHASE_ITEMS  = 200;
   localparam longint TWO_PI_FIX   = 64'sh6_487E_D511;
   localparam longint PI_FIX       = 64'sh3_243F_6A88;

   typedef struct {
      logic [31:0] sine;
      logic [4:0]  terms;
      logic        limit;
   } sine_result_type;

   class sine_scoreboard;
      logic [sts_pkg::TOL_W-1:0] tol_q30;
      sine_result_type expected_q[$];
      int errors;
      int checked;
      int limit_count;
      int sat_count;

      function new();
         tol_q30 = sts_pkg::TOL_RESET;
      endfunction

      function void note_angle(logic [31:0] angle);
         longint a32, k, c, sum;
         bit [63:0] mag, c2, t, prod, divisor;
         bit neg, done;
         int count, l;
         sine_result_type r;
         a32 = longint'($signed(angle)) * 256;
         k = a32 / TWO_PI_FIX;
         c = a32 - k * TWO_PI_FIX;
         if (c > PI_FIX) begin
            c = c - TWO_PI_FIX;
         end else if (c < -PI_FIX) begin
            c = c + TWO_PI_FIX;
         end
         neg = (c < 0);
         mag = neg ? -c : c;
         mag = mag >> 2;
         c2 = (mag * mag) >> 30;
         t = mag;
         sum = neg ? -longint'(mag) : longint'(mag);
         count = 1;
         l = 2;
         done = 1'b0;
         // each term from the previous one: times c^2, over l(l+1), sign flipped
         while (count < SERIES_TERMS && !done) begin
            prod = t * (c2 >> 30) + ((t * (c2 & 64'h3FFF_FFFF)) >> 30);
            divisor = 64'(l * (l + 1));
            t = prod / divisor;
            l = l + 2;
            neg = !neg;
            if (neg) begin
               sum = sum - longint'(t);
            end else begin
               sum = sum + longint'(t);
            end
            count++;
            if (t < tol_q30) begin
               done = 1'b1;
            end
         end
         if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
            sat_count++;
         end else if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
            sat_count++;
         end
         r.sine  = sum[31:0];
         r.terms = count[4:0];
         r.limit = !done;
         if (!done) begin
            limit_count++;
         end
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [31:0] sine, logic [4:0] terms, logic limit);
         sine_result_type exp_r;
         if (expected_q.size() == 0) begin
            $display("%0t: result with no request pending: sine %h terms %0d limit %0b",
                     $time, sine, terms, limit);
            errors++;
            return;
         end
         exp_r = expected_q.pop_front();
         checked++;
         if (sine !== exp_r.sine) begin
            $display("%0t: sine_value mismatch: expected %h actual %h",
                     $time, exp_r.sine, sine);
            errors++;
         end
         if (terms !== exp_r.terms) begin
            $display("%0t: terms_used mismatch: expected %0d actual %0d",
                     $time, exp_r.terms, terms);
            errors++;
         end
         if (limit !== exp_r.limit) begin
            $display("%0t: limit_hit mismatch: expected %0b actual %0b",
                     $time, exp_r.limit, limit);
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [31:0]               req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [39:0]               rsp_tdata;
   logic [0:0]                rsp_tuser;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [sts_pkg::TOL_W-1:0] csr_data;

   sine_scoreboard sb = new();
   bit idle_on = 1'b1;
   int rsp_hold_cycles = 0;

   sine_taylor_series #(
      .MAX_TERMS(SERIES_TERMS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_angle(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata[31:0], rsp_tdata[36:32], rsp_tuser[0]);
         end
      end
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_tready <= !(idle_on && $urandom_range(99) < 15);
         end
      end
   end

   task automatic send_angle(input logic [31:0] angle);
      while (idle_on && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= angle;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_tolerance(input logic [sts_pkg::TOL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.tol_q30 = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_results_drained();
      do @(negedge clock); while (sb.expected_q.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   initial begin
      logic [31:0] corner_angles[$];
      logic [sts_pkg::TOL_W-1:0] tol_plan[PHASES];
      logic [31:0] angle;
      longint near_pi;
      int pick;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;

      // zero, extremes, both sides of +-pi and +-2pi, quarter turns, bit patterns
      corner_angles = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h0324_3F6A, 32'h0324_3F6B, 32'hFCDB_C096,
                        32'hFCDB_C095, 32'h0648_7ED5, 32'h0648_7ED6, 32'hF9B7_812B,
                        32'hF9B7_812A, 32'h0192_1FB5, 32'hFE6D_E04B, 32'h096C_BE40,
                        32'hF693_41C0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0100,
                        32'h0400_0000, 32'hFC00_0000};

      tol_plan[0] = sts_pkg::TOL_RESET;
      tol_plan[1] = '0;
      tol_plan[2] = 31'd1;
      tol_plan[3] = 31'h4000_0000;
      tol_plan[4] = 31'h7FFF_FFFF;
      tol_plan[5] = sts_pkg::TOL_W'($urandom_range(1, 32'h4000_0000));
      tol_plan[6] = sts_pkg::TOL_W'($urandom_range(1, 32'h0000_FFFF));
      tol_plan[7] = sts_pkg::TOL_RESET;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            write_tolerance(tol_plan[p]);
         end
         idle_on = (p != 3);
         if (p == 0) begin
            foreach (corner_angles[i]) begin
               send_angle(corner_angles[i]);
            end
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == 20) begin
               rsp_hold_cycles = 300;
            end
            pick = $urandom_range(99);
            if (pick < 60) begin
               angle = $urandom;
            end else if (pick < 85) begin
               angle = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
            end else begin
               // near a multiple of pi, where the wrap decides the sign
               near_pi = (longint'($urandom_range(0, 80)) - 40) * PI_FIX / 256;
               angle = near_pi[31:0] + $urandom_range(0, 64) - 32;
            end
            send_angle(angle);
         end
         req_tvalid <= 1'b0;
         wait_results_drained();
      end

      repeat (200) @(negedge clock);
      $display("checked %0d sine results over %0d tolerance settings", sb.checked, PHASES);
      $display("%0d stopped at the term limit, %0d saturated", sb.limit_count, sb.sat_count);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
